FILE: rtl/ulfc_pkg.sv
// ulfc_pkg: types, codes and fold tables for the utf-8 latin fold classifier
// no dependencies; imported by ulfc_decode, ulfc_classify and the top level
package ulfc_pkg;

    // lead and continuation byte codes
    localparam logic [7:0] LEAD_C3   = 8'hc3;
    localparam logic [7:0] LEAD_C2   = 8'hc2;
    localparam logic [7:0] LEAD_E2   = 8'he2;
    localparam logic [7:0] CONT_80   = 8'h80;
    localparam logic [7:0] GUIL_L    = 8'hab;
    localparam logic [7:0] GUIL_R    = 8'hbb;
    localparam logic [7:0] QUOTE_DL  = 8'h9c;
    localparam logic [7:0] QUOTE_DR  = 8'h9d;
    localparam logic [7:0] DASH_EN   = 8'h93;
    localparam logic [7:0] ELLIPSIS  = 8'ha6;
    localparam logic [7:0] QUOTE_SL  = 8'h98;
    localparam logic [7:0] QUOTE_SR  = 8'h99;

    // ascii codes used by the fold and the classes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_NONE   = 8'h00;

    // pending-sequence state
    typedef enum logic [2:0] {
        PFX_IDLE = 3'd0,
        PFX_C3   = 3'd1,
        PFX_C2   = 3'd2,
        PFX_E2   = 3'd3,
        PFX_E280 = 3'd4
    } t_prefix;

    // decoder result for one byte
    typedef struct packed {
        logic       has_result;
        logic [7:0] char;
    } t_dec;

    // class flags of one folded character
    typedef struct packed {
        logic vowel;
        logic consonant;
        logic in_word;
        logic space;
        logic punct;
        logic separation;
        logic merge;
    } t_flags;

    // second byte after c3 folded to a plain lower-case letter, 0 if unknown
    function automatic logic [7:0] fold_accent(input logic [7:0] b);
        logic [7:0] c;
        c = CH_NONE;
        unique case (b)
            8'h87, 8'ha7:                               c = "c";
            8'ha0, 8'ha1, 8'ha2, 8'ha3,
            8'h80, 8'h81, 8'h82, 8'h83:                 c = "a";
            8'ha8, 8'ha9, 8'haa, 8'h88, 8'h89, 8'h8a:   c = "e";
            8'hac, 8'had, 8'h8c, 8'h8d:                 c = "i";
            8'hb2, 8'hb3, 8'hb4, 8'hb5,
            8'h92, 8'h93, 8'h94, 8'h95:                 c = "o";
            8'hb9, 8'hba, 8'h99, 8'h9a:                 c = "u";
            default:                                    c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/ulfc_byte_if.sv
// ulfc_byte_if: valid/ready channel carrying one raw utf-8 byte
// no dependencies
interface ulfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/ulfc_result_if.sv
// ulfc_result_if: valid/ready channel carrying one folded character and its flags
// no dependencies
interface ulfc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       flag_vowel;
    logic       flag_consonant;
    logic       flag_in_word;
    logic       flag_space;
    logic       flag_punct;
    logic       flag_separation;
    logic       flag_merge;

    modport source (
        output valid, output out_char, output flag_vowel, output flag_consonant,
        output flag_in_word, output flag_space, output flag_punct,
        output flag_separation, output flag_merge, input ready
    );
    modport sink (
        input valid, input out_char, input flag_vowel, input flag_consonant,
        input flag_in_word, input flag_space, input flag_punct,
        input flag_separation, input flag_merge, output ready
    );
endinterface

FILE: rtl/ulfc_decode.sv
// ulfc_decode: next-state and fold logic of the pending-sequence state machine
// depends on ulfc_pkg
module ulfc_decode
    import ulfc_pkg::*;
(
    input  t_prefix    i_state,
    input  logic [7:0] i_byte,
    output t_prefix    o_next_state,
    output t_dec       o_dec
);

    // next state: lead bytes open a sequence, e2 80 extends it
    always_comb begin
        o_next_state = PFX_IDLE;
        unique case (i_state)
            PFX_E2: begin
                o_next_state = (i_byte == CONT_80) ? PFX_E280 : PFX_IDLE;
            end
            PFX_C3, PFX_C2, PFX_E280: begin
                o_next_state = PFX_IDLE;
            end
            default: begin
                priority if (i_byte == LEAD_C3) begin
                    o_next_state = PFX_C3;
                end else if (i_byte == LEAD_C2) begin
                    o_next_state = PFX_C2;
                end else if (i_byte == LEAD_E2) begin
                    o_next_state = PFX_E2;
                end else begin
                    o_next_state = PFX_IDLE;
                end
            end
        endcase
    end

    // output: folded character, or no item while a sequence is pending
    always_comb begin
        o_dec.has_result = 1'b1;
        o_dec.char       = i_byte;
        unique case (i_state)
            PFX_C3: begin
                o_dec.char = fold_accent(i_byte);
            end
            PFX_C2: begin
                if (i_byte == GUIL_L || i_byte == GUIL_R) begin
                    o_dec.char = CH_SPACE;
                end
            end
            PFX_E2: begin
                o_dec.has_result = (i_byte != CONT_80);
            end
            PFX_E280: begin
                priority if (i_byte == QUOTE_DL || i_byte == QUOTE_DR) begin
                    o_dec.char = CH_DASH;
                end else if (i_byte == DASH_EN || i_byte == ELLIPSIS) begin
                    o_dec.char = CH_DOT;
                end else if (i_byte == QUOTE_SL || i_byte == QUOTE_SR) begin
                    o_dec.char = CH_APOS;
                end else begin
                    o_dec.char = i_byte;
                end
            end
            default: begin
                o_dec.has_result = !(i_byte == LEAD_C3 || i_byte == LEAD_C2 ||
                                     i_byte == LEAD_E2);
            end
        endcase
    end

endmodule

FILE: rtl/ulfc_classify.sv
// ulfc_classify: ascii class flags of one folded character
// depends on ulfc_pkg
module ulfc_classify
    import ulfc_pkg::*;
(
    input  logic [7:0] i_char,
    output t_flags     o_flags
);

    logic       upper;
    logic       lower;
    logic       letter;
    logic       digit;
    logic [7:0] low_case;
    logic       vowel_code;

    // letter and digit ranges
    assign upper    = (i_char >= "A") && (i_char <= "Z");
    assign lower    = (i_char >= "a") && (i_char <= "z");
    assign letter   = upper || lower;
    assign digit    = (i_char >= "0") && (i_char <= "9");
    assign low_case = i_char | 8'h20;
    assign vowel_code = (low_case == "a") || (low_case == "e") || (low_case == "i") ||
                        (low_case == "o") || (low_case == "u");

    // class flags
    always_comb begin
        o_flags.vowel      = letter && vowel_code;
        o_flags.consonant  = letter && !vowel_code;
        o_flags.in_word    = letter || digit || (i_char == CH_APOS) || (i_char == CH_UNDER);
        o_flags.space      = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_LF);
        o_flags.punct      = (i_char == ".") || (i_char == ",") || (i_char == ":") ||
                             (i_char == ";") || (i_char == "?") || (i_char == "!");
        o_flags.separation = (i_char == "-") || (i_char == "\"") || (i_char == "[") ||
                             (i_char == "]") || (i_char == "(") || (i_char == ")");
        o_flags.merge      = (i_char == CH_APOS);
    end

endmodule

FILE: rtl/utf8_latin_fold_classifier.sv
// utf8_latin_fold_classifier: top level, input register, prefix state, result register
// depends on ulfc_pkg, ulfc_byte_if, ulfc_result_if, ulfc_decode, ulfc_classify
//
// usage
//   i_in carries one raw utf-8 byte per item (valid/ready, taken when both high).
//   o_out carries one folded character with its class flags per item.
//   lead bytes c3, c2 and e2 while no sequence is pending, and the 80 after e2,
//   give no output item; every other byte completes a character and gives exactly one output item.
// registers and throughput
//   a byte is captured in the input register when it is accepted; its result is
//   then loaded into the result register, which drives o_out, once that register
//   is free. one byte per cycle is sustained while o_out is not held; the only loop
//   is the 3-bit prefix state, updated by short logic in the same cycle.
// stalls
//   while o_out is held (valid without ready) the result register holds; the
//   input register still advances bytes that give no output item, and i_in
//   accepts a new byte whenever the input register empties in the same cycle.
// reset
//   i_rst_n is synchronous and active low: both registers empty, prefix idle.
module utf8_latin_fold_classifier
    import ulfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    ulfc_byte_if.sink          i_in,
    ulfc_result_if.source      o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_prefix    r_state;
    t_prefix    n_state;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    t_flags     r_out_flags;
    t_dec       dec;
    t_flags     flags;
    logic       out_free;
    logic       advance;
    logic       in_take;

    // fold and state logic on the registered byte
    ulfc_decode u_decode (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .o_next_state (n_state),
        .o_dec        (dec)
    );

    // classes of the folded character
    ulfc_classify u_classify (
        .i_char  (dec.char),
        .o_flags (flags)
    );

    // handshake control
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!dec.has_result || out_free);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // prefix state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PFX_IDLE;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && dec.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec.has_result) begin
            r_out_char  <= dec.char;
            r_out_flags <= flags;
        end
    end

    // output channel
    assign o_out.valid           = r_out_valid;
    assign o_out.out_char        = r_out_char;
    assign o_out.flag_vowel      = r_out_flags.vowel;
    assign o_out.flag_consonant  = r_out_flags.consonant;
    assign o_out.flag_in_word    = r_out_flags.in_word;
    assign o_out.flag_space      = r_out_flags.space;
    assign o_out.flag_punct      = r_out_flags.punct;
    assign o_out.flag_separation = r_out_flags.separation;
    assign o_out.flag_merge      = r_out_flags.merge;

`ifndef NO_ASSERTIONS
    // a byte waiting in the input register is neither lost nor changed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost or changed a waiting item");

    // e2 80 only ever follows e2
    a_e280_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($changed(r_state) && r_state == PFX_E280) |-> ($past(r_state) == PFX_E2))
        else $error("prefix state reached e2 80 without e2");

    // a result waiting on a stalled receiver is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(advance && dec.has_result))
        else $error("result register overwritten while stalled");

    // the main classes exclude each other
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($countones({r_out_flags.vowel, r_out_flags.consonant,
            r_out_flags.space, r_out_flags.punct, r_out_flags.separation}) <= 1))
        else $error("character in more than one class");

    // an apostrophe is always part of a word
    a_merge_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flags.merge) |-> r_out_flags.in_word)
        else $error("merge flag without in-word flag");
`endif

endmodule
